// File: sv/dkrc_pkg.sv
// ----------------------------------------------------------------------------
// dkrc_pkg - shared definitions for the distinct key range counter
// Field widths, default tree size, and the command bundle used between the
// top-level sequencer and the Fenwick tree walk unit.
// ----------------------------------------------------------------------------
package dkrc_pkg;

  // Width of every payload field (positions, keys, counts)
  localparam int FIELD_W = 13;

  // Default number of positions / keys
  localparam int NODES_DEF = 4096;

  // Tree walk operations
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_QUERY = 2'd2
  } tree_op_t;

  // Command from the sequencer to the tree unit
  typedef struct packed {
    logic     go;   // start a walk at the given index
    logic     clr;  // clear the node at the given index (reset sweep)
    tree_op_t op;
  } tree_cmd_t;

endpackage

// File: sv/dkrc_if.sv
// ----------------------------------------------------------------------------
// dkrc_if - valid/ready channels of the distinct key range counter
// Input channel carries one element (position, range end, key); output
// channel carries one distinct count.
// ----------------------------------------------------------------------------
interface dkrc_in_if;
  logic        valid;
  logic        ready;
  logic [12:0] start_pos;
  logic [12:0] end_pos;
  logic [12:0] key_id;

  modport source (output valid, output start_pos, output end_pos, output key_id,
                  input ready);
  modport sink   (input valid, input start_pos, input end_pos, input key_id,
                  output ready);
endinterface

interface dkrc_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] distinct_count;

  modport source (output valid, output distinct_count, input ready);
  modport sink   (input valid, input distinct_count, output ready);
endinterface

// File: sv/distinct_key_range_counter_top.sv
// ----------------------------------------------------------------------------
// distinct_key_range_counter_top - distinct keys within a position range
// Keeps the last marked position of every key and a Fenwick tree of 0/1
// marks; each element moves its key's mark and returns the mark count.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready, one transfer per element (start_pos, end_pos,
//            key_id). in_ch.ready is high only while the sequencer is idle.
//   out_ch : valid/ready, one distinct_count per element, in order.
//   Walks  : each element runs up to four tree walks in turn: the removal
//            walk, the insert walk and the two prefix walks (each at most
//            log2(NODES)+1 nodes). No new transfer is taken until the
//            result is loaded; the sequencer then returns to idle and can
//            take the next transfer. Every tree node takes a read and then
//            an update or accumulate on the tree memory.
//   Reset  : synchronous, active low. After reset a clearing sweep writes
//            zero to the key, mark and tree memories, one address per cycle,
//            addresses 0 to NODES, with in_ch.ready low.
//   Stall  : a finished count sits in the output register; the next element
//            may be accepted and processed meanwhile, but its result waits
//            in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module distinct_key_range_counter_top
  import dkrc_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dkrc_in_if.sink     in_ch,
  dkrc_out_if.source  out_ch
);

  localparam int AW = $clog2(NODES + 1);
  localparam int IW = AW + 1;

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_KEY_RD   = 14'b00000000000100,
    S_OLD      = 14'b00000000001000,
    S_OLD_MK   = 14'b00000000010000,
    S_OLD_WALK = 14'b00000000100000,
    S_NEW_RD   = 14'b00000001000000,
    S_NEW_MK   = 14'b00000010000000,
    S_NEW_WALK = 14'b00000100000000,
    S_QHI      = 14'b00001000000000,
    S_QHI_W    = 14'b00010000000000,
    S_QLO      = 14'b00100000000000,
    S_QLO_W    = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_idx_r, clr_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]  out_data_r, out_data_nxt;

  // element context
  logic [FIELD_W-1:0]  start_r, start_nxt;
  logic [FIELD_W-1:0]  key_r, key_nxt;
  logic [FIELD_W-1:0]  lo_r, lo_nxt;
  logic [FIELD_W-1:0]  hi_r, hi_nxt;
  logic                key_ok_r, key_ok_nxt;
  logic                pos_ok_r, pos_ok_nxt;
  logic                range_ok_r, range_ok_nxt;
  logic [FIELD_W-1:0]  old_r, old_nxt;
  logic [FIELD_W-1:0]  sum_hi_r, sum_hi_nxt;
  logic [FIELD_W-1:0]  count_r, count_nxt;

  // key and mark memories
  logic [FIELD_W-1:0]  key_mem  [0:NODES];
  logic                mark_mem [0:NODES];
  logic [FIELD_W-1:0]  key_rd_r;
  logic                mark_rd_r;
  logic                key_we, key_re;
  logic [AW-1:0]       key_wa;
  logic [FIELD_W-1:0]  key_wd;
  logic                mark_we, mark_re, mark_wd;
  logic [AW-1:0]       mark_wa, mark_ra;

  // tree unit
  tree_cmd_t           tcmd;
  logic [IW-1:0]       tidx;
  logic                tdone;
  logic [FIELD_W-1:0]  tsum;

  // input decode at accept
  logic [FIELD_W-1:0]  in_lo, in_hi;

  assign in_lo = (in_ch.start_pos == '0) ? FIELD_W'(1) : in_ch.start_pos;
  assign in_hi = (int'(in_ch.end_pos) > NODES) ? FIELD_W'(NODES) : in_ch.end_pos;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.distinct_count = out_data_r;

  dkrc_tree #(
    .NODES (NODES)
  ) u_tree (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tcmd),
    .idx   (tidx),
    .done  (tdone),
    .sum   (tsum)
  );

  // main sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    start_nxt     = start_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    key_ok_nxt    = key_ok_r;
    pos_ok_nxt    = pos_ok_r;
    range_ok_nxt  = range_ok_r;
    old_nxt       = old_r;
    sum_hi_nxt    = sum_hi_r;
    count_nxt     = count_r;
    key_we        = 1'b0;
    key_re        = 1'b0;
    key_wa        = AW'(key_r);
    key_wd        = start_r;
    mark_we       = 1'b0;
    mark_re       = 1'b0;
    mark_wa       = AW'(start_r);
    mark_wd       = 1'b0;
    mark_ra       = AW'(start_r);
    tcmd          = '{go: 1'b0, clr: 1'b0, op: OP_QUERY};
    tidx          = IW'(start_r);

    // output register drains independently
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        key_we   = 1'b1;
        key_wa   = clr_idx_r;
        key_wd   = '0;
        mark_we  = 1'b1;
        mark_wa  = clr_idx_r;
        tcmd.clr = 1'b1;
        tidx     = IW'(clr_idx_r);
        if (clr_idx_r == AW'(NODES)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          start_nxt    = in_ch.start_pos;
          key_nxt      = in_ch.key_id;
          lo_nxt       = in_lo;
          hi_nxt       = in_hi;
          key_ok_nxt   = (in_ch.key_id != '0) && (int'(in_ch.key_id) <= NODES);
          pos_ok_nxt   = (in_ch.start_pos != '0) && (int'(in_ch.start_pos) <= NODES);
          range_ok_nxt = (in_lo <= in_hi);
          state_nxt    = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        key_re    = key_ok_r;
        state_nxt = S_OLD;
      end
      S_OLD: begin
        // previous position of this key, if any
        if (key_ok_r && (key_rd_r != '0)) begin
          old_nxt   = key_rd_r;
          mark_re   = 1'b1;
          mark_ra   = AW'(key_rd_r);
          state_nxt = S_OLD_MK;
        end else begin
          state_nxt = S_NEW_RD;
        end
      end
      S_OLD_MK: begin
        if (mark_rd_r) begin
          mark_we   = 1'b1;
          mark_wa   = AW'(old_r);
          mark_wd   = 1'b0;
          tcmd.go   = 1'b1;
          tcmd.op   = OP_SUB;
          tidx      = IW'(old_r);
          state_nxt = S_OLD_WALK;
        end else begin
          state_nxt = S_NEW_RD;
        end
      end
      S_OLD_WALK: begin
        if (tdone) begin
          state_nxt = S_NEW_RD;
        end
      end
      S_NEW_RD: begin
        if (pos_ok_r) begin
          mark_re   = 1'b1;
          mark_ra   = AW'(start_r);
          key_we    = key_ok_r;
          state_nxt = S_NEW_MK;
        end else begin
          state_nxt = S_QHI;
        end
      end
      S_NEW_MK: begin
        if (!mark_rd_r) begin
          mark_we   = 1'b1;
          mark_wa   = AW'(start_r);
          mark_wd   = 1'b1;
          tcmd.go   = 1'b1;
          tcmd.op   = OP_ADD;
          tidx      = IW'(start_r);
          state_nxt = S_NEW_WALK;
        end else begin
          state_nxt = S_QHI;
        end
      end
      S_NEW_WALK: begin
        if (tdone) begin
          state_nxt = S_QHI;
        end
      end
      S_QHI: begin
        if (range_ok_r) begin
          tcmd.go   = 1'b1;
          tcmd.op   = OP_QUERY;
          tidx      = IW'(hi_r);
          state_nxt = S_QHI_W;
        end else begin
          count_nxt = '0;
          state_nxt = S_DONE;
        end
      end
      S_QHI_W: begin
        if (tdone) begin
          sum_hi_nxt = tsum;
          state_nxt  = S_QLO;
        end
      end
      S_QLO: begin
        tcmd.go   = 1'b1;
        tcmd.op   = OP_QUERY;
        tidx      = IW'(lo_r - FIELD_W'(1));
        state_nxt = S_QLO_W;
      end
      S_QLO_W: begin
        if (tdone) begin
          count_nxt = sum_hi_r - tsum;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // element context and output payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    start_r    <= start_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    key_ok_r   <= key_ok_nxt;
    pos_ok_r   <= pos_ok_nxt;
    range_ok_r <= range_ok_nxt;
    old_r      <= old_nxt;
    sum_hi_r   <= sum_hi_nxt;
    count_r    <= count_nxt;
  end

  // last position per key
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (key_re) begin
      key_rd_r <= key_mem[AW'(key_r)];
    end
  end

  // live mark per position
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (mark_re) begin
      mark_rd_r <= mark_mem[mark_ra];
    end
  end

endmodule

// File: sv/dkrc_tree.sv
// ----------------------------------------------------------------------------
// dkrc_tree - Fenwick tree store with an iterative walk unit
// Holds the partial sums in a single-port-write / registered-read memory.
// One shared adder/lowbit unit walks the tree node by node (read, then op):
// update walks go upward (+/-1 per node), prefix queries go downward accumulating.
// ----------------------------------------------------------------------------
module dkrc_tree
  import dkrc_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tree_cmd_t                    cmd,
  input  logic [$clog2(NODES+1):0]     idx,
  output logic                         done,
  output logic [FIELD_W-1:0]           sum
);

  localparam int AW = $clog2(NODES + 1);
  localparam int IW = AW + 1;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RD   = 3'b010,
    T_OP   = 3'b100
  } tstate_t;

  tstate_t             tstate_r, tstate_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  tree_op_t            op_r, op_nxt;
  logic [FIELD_W-1:0]  acc_r, acc_nxt;

  logic [FIELD_W-1:0]  fen_mem [0:NODES];
  logic [FIELD_W-1:0]  rdata_r;

  logic                we;
  logic [AW-1:0]       wa;
  logic [FIELD_W-1:0]  wd;
  logic                re;
  logic [IW-1:0]       lowbit;
  logic                in_range;

  // lowest set bit of the walk index, and walk termination check
  assign lowbit   = idx_r & (~idx_r + IW'(1));
  assign in_range = (idx_r != '0) && (idx_r <= IW'(NODES));
  assign sum      = acc_r;

  // walk sequencer
  always_comb begin
    tstate_nxt = tstate_r;
    idx_nxt    = idx_r;
    op_nxt     = op_r;
    acc_nxt    = acc_r;
    we         = 1'b0;
    wa         = idx_r[AW-1:0];
    wd         = '0;
    re         = 1'b0;
    done       = 1'b0;
    unique case (tstate_r)
      T_IDLE: begin
        if (cmd.clr) begin
          we = 1'b1;
          wa = idx[AW-1:0];
        end
        if (cmd.go) begin
          idx_nxt    = idx;
          op_nxt     = cmd.op;
          acc_nxt    = '0;
          tstate_nxt = T_RD;
        end
      end
      T_RD: begin
        if (in_range) begin
          re         = 1'b1;
          tstate_nxt = T_OP;
        end else begin
          done       = 1'b1;
          tstate_nxt = T_IDLE;
        end
      end
      T_OP: begin
        tstate_nxt = T_RD;
        case (op_r)
          OP_QUERY: begin
            acc_nxt = acc_r + rdata_r;
            idx_nxt = idx_r - lowbit;
          end
          OP_ADD: begin
            we      = 1'b1;
            wd      = rdata_r + FIELD_W'(1);
            idx_nxt = idx_r + lowbit;
          end
          OP_SUB: begin
            we      = 1'b1;
            wd      = rdata_r - FIELD_W'(1);
            idx_nxt = idx_r + lowbit;
          end
          default: begin
            tstate_nxt = T_IDLE;
          end
        endcase
      end
      default: tstate_nxt = T_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tstate_r <= T_IDLE;
    end else begin
      tstate_r <= tstate_nxt;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
  end

  // partial-sum memory
  always_ff @(posedge clk) begin
    if (we) begin
      fen_mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= fen_mem[idx_r[AW-1:0]];
    end
  end

endmodule

// File: sv/dkrc_checker.sv
// ----------------------------------------------------------------------------
// dkrc_checker - port-level checks for the distinct key range counter
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module dkrc_checker
  import dkrc_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] distinct_count
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one element at a time: no accept in the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // a new result is loaded only as the sequencer returns to idle
  a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while sequencer busy");

  // a count can never exceed the number of positions
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(distinct_count) <= NODES))
    else $error("distinct count above position range");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind distinct_key_range_counter_top dkrc_checker #(
  .NODES (NODES)
) u_dkrc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .distinct_count (out_ch.distinct_count)
);
